FILE: hw/rtl/assert_macros.svh
// -----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; they expand to nothing under synthesis.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed (same cycle)");
`define ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed (next cycle)");
`else
`define ASSERT_IMP(name, clk, rst, ante, cons)
`define ASSERT_NEXT(name, clk, rst, ante, cons)
`endif

`endif

FILE: hw/rtl/segint_pkg.sv
// -----------------------------------------------------------------------------
// Segment intersection package
// Widths, transaction payloads and inter-stage types.
// -----------------------------------------------------------------------------
`default_nettype none

package segint_pkg;

   localparam int COORD_W = 24;
   localparam int DIFF_W  = COORD_W + 1;
   localparam int PROD_W  = 2 * DIFF_W;
   localparam int CROSS_W = PROD_W + 1;
   localparam int MAG_W   = CROSS_W - 1;
   localparam int SMAG_W  = COORD_W;
   localparam int LO_W    = (MAG_W + 1) / 2;
   localparam int HI_W    = MAG_W - LO_W;
   localparam int NUM_W   = MAG_W + SMAG_W;
   localparam int QUO_W   = COORD_W;

   typedef logic signed [COORD_W-1:0] coord_type;

   typedef struct packed {
      coord_type a_start_x;
      coord_type a_start_y;
      coord_type a_end_x;
      coord_type a_end_y;
      coord_type b_start_x;
      coord_type b_start_y;
      coord_type b_end_x;
      coord_type b_end_y;
   } req_type;

   typedef struct packed {
      logic      hit;
      coord_type cross_x;
      coord_type cross_y;
   } rsp_type;

   typedef struct packed {
      logic               hit;
      logic [MAG_W-1:0]   dmag;
      logic [MAG_W-1:0]   tmag;
      logic [SMAG_W-1:0]  smag_x;
      logic [SMAG_W-1:0]  smag_y;
      logic               sneg_x;
      logic               sneg_y;
      coord_type          p0x;
      coord_type          p0y;
   } front_type;

   typedef struct packed {
      logic              hit;
      logic [MAG_W-1:0]  dmag;
      logic [NUM_W-1:0]  num_x;
      logic [NUM_W-1:0]  num_y;
      logic              sneg_x;
      logic              sneg_y;
      coord_type         p0x;
      coord_type         p0y;
   } scale_type;

   typedef struct packed {
      logic [MAG_W-1:0] rem;
      logic [QUO_W-1:0] low;
   } lane_type;

   typedef struct packed {
      logic             hit;
      logic [MAG_W-1:0] dmag;
      lane_type         lx;
      lane_type         ly;
      logic             sneg_x;
      logic             sneg_y;
      coord_type        p0x;
      coord_type        p0y;
   } div_type;

endpackage

`default_nettype wire

FILE: hw/rtl/segint_front.sv
// -----------------------------------------------------------------------------
// Segment intersection front end
// Four stages: direction vectors, cross products, numerator and denominator
// differences, then the hit test and magnitudes.
// -----------------------------------------------------------------------------
`default_nettype none

module segint_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  segint_pkg::req_type   in_data,
   output logic                  out_valid,
   output segint_pkg::front_type out_data
);

   import segint_pkg::*;

   typedef struct packed {
      logic signed [DIFF_W-1:0] s1x;
      logic signed [DIFF_W-1:0] s1y;
      logic signed [DIFF_W-1:0] s2x;
      logic signed [DIFF_W-1:0] s2y;
      logic signed [DIFF_W-1:0] dx;
      logic signed [DIFF_W-1:0] dy;
      coord_type                p0x;
      coord_type                p0y;
   } diff_type;

   typedef struct packed {
      logic signed [PROD_W-1:0] den_a;
      logic signed [PROD_W-1:0] den_b;
      logic signed [PROD_W-1:0] sn_a;
      logic signed [PROD_W-1:0] sn_b;
      logic signed [PROD_W-1:0] tn_a;
      logic signed [PROD_W-1:0] tn_b;
      logic [SMAG_W-1:0]        smag_x;
      logic [SMAG_W-1:0]        smag_y;
      logic                     sneg_x;
      logic                     sneg_y;
      coord_type                p0x;
      coord_type                p0y;
   } prod_type;

   typedef struct packed {
      logic signed [CROSS_W-1:0] den;
      logic signed [CROSS_W-1:0] sn;
      logic signed [CROSS_W-1:0] tn;
      logic [SMAG_W-1:0]         smag_x;
      logic [SMAG_W-1:0]         smag_y;
      logic                      sneg_x;
      logic                      sneg_y;
      coord_type                 p0x;
      coord_type                 p0y;
   } cross_type;

   diff_type  d1_in, d1_ff;
   prod_type  d2_in, d2_ff;
   cross_type d3_in, d3_ff;
   front_type d4_in, d4_ff;
   logic      v1_ff, v2_ff, v3_ff, v4_ff;

   logic signed [DIFF_W-1:0]  s1x_neg, s1y_neg;
   logic signed [CROSS_W-1:0] den, sn, tn, den_neg, tn_neg;
   logic                      den_pos, hit_pos, hit_neg;

   // stage 1: direction vectors
   always_comb begin
      d1_in.s1x = DIFF_W'(in_data.a_end_x) - DIFF_W'(in_data.a_start_x);
      d1_in.s1y = DIFF_W'(in_data.a_end_y) - DIFF_W'(in_data.a_start_y);
      d1_in.s2x = DIFF_W'(in_data.b_end_x) - DIFF_W'(in_data.b_start_x);
      d1_in.s2y = DIFF_W'(in_data.b_end_y) - DIFF_W'(in_data.b_start_y);
      d1_in.dx  = DIFF_W'(in_data.a_start_x) - DIFF_W'(in_data.b_start_x);
      d1_in.dy  = DIFF_W'(in_data.a_start_y) - DIFF_W'(in_data.b_start_y);
      d1_in.p0x = in_data.a_start_x;
      d1_in.p0y = in_data.a_start_y;
   end

   // stage 2: products, segment A direction magnitudes
   assign s1x_neg = -d1_ff.s1x;
   assign s1y_neg = -d1_ff.s1y;

   always_comb begin
      d2_in.den_a  = d1_ff.s1x * d1_ff.s2y;
      d2_in.den_b  = d1_ff.s2x * d1_ff.s1y;
      d2_in.sn_a   = d1_ff.s1x * d1_ff.dy;
      d2_in.sn_b   = d1_ff.s1y * d1_ff.dx;
      d2_in.tn_a   = d1_ff.s2x * d1_ff.dy;
      d2_in.tn_b   = d1_ff.s2y * d1_ff.dx;
      d2_in.smag_x = d1_ff.s1x[DIFF_W-1] ? s1x_neg[SMAG_W-1:0] : d1_ff.s1x[SMAG_W-1:0];
      d2_in.smag_y = d1_ff.s1y[DIFF_W-1] ? s1y_neg[SMAG_W-1:0] : d1_ff.s1y[SMAG_W-1:0];
      d2_in.sneg_x = d1_ff.s1x[DIFF_W-1];
      d2_in.sneg_y = d1_ff.s1y[DIFF_W-1];
      d2_in.p0x    = d1_ff.p0x;
      d2_in.p0y    = d1_ff.p0y;
   end

   // stage 3: denominator and numerators
   always_comb begin
      d3_in.den    = CROSS_W'(d2_ff.den_a) - CROSS_W'(d2_ff.den_b);
      d3_in.sn     = CROSS_W'(d2_ff.sn_a) - CROSS_W'(d2_ff.sn_b);
      d3_in.tn     = CROSS_W'(d2_ff.tn_a) - CROSS_W'(d2_ff.tn_b);
      d3_in.smag_x = d2_ff.smag_x;
      d3_in.smag_y = d2_ff.smag_y;
      d3_in.sneg_x = d2_ff.sneg_x;
      d3_in.sneg_y = d2_ff.sneg_y;
      d3_in.p0x    = d2_ff.p0x;
      d3_in.p0y    = d2_ff.p0y;
   end

   // stage 4: hit test on raw signs, no normalising negate in the compare path
   assign den     = d3_ff.den;
   assign sn      = d3_ff.sn;
   assign tn      = d3_ff.tn;
   assign den_neg = -den;
   assign tn_neg  = -tn;
   assign den_pos = !den[CROSS_W-1];
   assign hit_pos = !sn[CROSS_W-1] && (sn <= den) && !tn[CROSS_W-1] && (tn <= den);
   assign hit_neg = (sn[CROSS_W-1] || !(|sn)) && (sn >= den)
                    && (tn[CROSS_W-1] || !(|tn)) && (tn >= den);

   always_comb begin
      d4_in.hit    = (|den) && (den_pos ? hit_pos : hit_neg);
      d4_in.dmag   = den_pos ? den[MAG_W-1:0] : den_neg[MAG_W-1:0];
      d4_in.tmag   = tn[CROSS_W-1] ? tn_neg[MAG_W-1:0] : tn[MAG_W-1:0];
      d4_in.smag_x = d3_ff.smag_x;
      d4_in.smag_y = d3_ff.smag_y;
      d4_in.sneg_x = d3_ff.sneg_x;
      d4_in.sneg_y = d3_ff.sneg_y;
      d4_in.p0x    = d3_ff.p0x;
      d4_in.p0y    = d3_ff.p0y;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d1_ff <= d1_in;
         d2_ff <= d2_in;
         d3_ff <= d3_in;
         d4_ff <= d4_in;
      end
   end

   assign out_valid = v4_ff;
   assign out_data  = d4_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/segint_scale.sv
// -----------------------------------------------------------------------------
// Segment intersection scaler
// Forms |T| * |s1| for x and y from split partial products over two stages.
// -----------------------------------------------------------------------------
`default_nettype none

module segint_scale (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  segint_pkg::front_type in_data,
   output logic                  out_valid,
   output segint_pkg::scale_type out_data
);

   import segint_pkg::*;

   typedef struct packed {
      logic                     hit;
      logic [MAG_W-1:0]         dmag;
      logic [LO_W+SMAG_W-1:0]   lo_x;
      logic [HI_W+SMAG_W-1:0]   hi_x;
      logic [LO_W+SMAG_W-1:0]   lo_y;
      logic [HI_W+SMAG_W-1:0]   hi_y;
      logic                     sneg_x;
      logic                     sneg_y;
      coord_type                p0x;
      coord_type                p0y;
   } pp_type;

   pp_type    p1_in, p1_ff;
   scale_type p2_in, p2_ff;
   logic      v1_ff, v2_ff;

   logic [LO_W-1:0] t_lo;
   logic [HI_W-1:0] t_hi;

   assign t_lo = in_data.tmag[LO_W-1:0];
   assign t_hi = in_data.tmag[MAG_W-1:LO_W];

   always_comb begin
      p1_in.hit    = in_data.hit;
      p1_in.dmag   = in_data.dmag;
      p1_in.lo_x   = t_lo * in_data.smag_x;
      p1_in.hi_x   = t_hi * in_data.smag_x;
      p1_in.lo_y   = t_lo * in_data.smag_y;
      p1_in.hi_y   = t_hi * in_data.smag_y;
      p1_in.sneg_x = in_data.sneg_x;
      p1_in.sneg_y = in_data.sneg_y;
      p1_in.p0x    = in_data.p0x;
      p1_in.p0y    = in_data.p0y;
   end

   always_comb begin
      p2_in.hit    = p1_ff.hit;
      p2_in.dmag   = p1_ff.dmag;
      p2_in.num_x  = (NUM_W'(p1_ff.hi_x) << LO_W) + NUM_W'(p1_ff.lo_x);
      p2_in.num_y  = (NUM_W'(p1_ff.hi_y) << LO_W) + NUM_W'(p1_ff.lo_y);
      p2_in.sneg_x = p1_ff.sneg_x;
      p2_in.sneg_y = p1_ff.sneg_y;
      p2_in.p0x    = p1_ff.p0x;
      p2_in.p0y    = p1_ff.p0y;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p1_ff <= p1_in;
         p2_ff <= p2_in;
      end
   end

   assign out_valid = v2_ff;
   assign out_data  = p2_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/segint_div.sv
// -----------------------------------------------------------------------------
// Segment intersection divider
// Pipelined restoring divider, one quotient bit per stage, x and y lanes
// sharing the denominator. Quotient fits QUO_W bits because |T| <= |D|.
// -----------------------------------------------------------------------------
`default_nettype none

module segint_div (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  segint_pkg::scale_type in_data,
   output logic                  out_valid,
   output segint_pkg::div_type   out_data
);

   import segint_pkg::*;

   function automatic lane_type lane_step(lane_type l, logic [MAG_W-1:0] d);
      logic [MAG_W:0] trial;
      logic [MAG_W:0] diff;
      lane_type       r;
      trial = {l.rem, l.low[QUO_W-1]};
      diff  = trial - {1'b0, d};
      if (trial >= {1'b0, d}) begin
         r.rem = diff[MAG_W-1:0];
         r.low = {l.low[QUO_W-2:0], 1'b1};
      end else begin
         r.rem = trial[MAG_W-1:0];
         r.low = {l.low[QUO_W-2:0], 1'b0};
      end
      return r;
   endfunction

   div_type          seed;
   div_type          src   [QUO_W];
   div_type          st_in [QUO_W];
   div_type          st_ff [QUO_W];
   logic [QUO_W-1:0] v_ff;

   always_comb begin
      seed.hit    = in_data.hit;
      seed.dmag   = in_data.dmag;
      seed.lx.rem = in_data.num_x[NUM_W-1:QUO_W];
      seed.lx.low = in_data.num_x[QUO_W-1:0];
      seed.ly.rem = in_data.num_y[NUM_W-1:QUO_W];
      seed.ly.low = in_data.num_y[QUO_W-1:0];
      seed.sneg_x = in_data.sneg_x;
      seed.sneg_y = in_data.sneg_y;
      seed.p0x    = in_data.p0x;
      seed.p0y    = in_data.p0y;
   end

   assign src[0] = seed;

   for (genvar i = 0; i < QUO_W; i++) begin : g_stage
      if (i > 0) begin : g_link
         assign src[i] = st_ff[i-1];
      end

      always_comb begin
         st_in[i]    = src[i];
         st_in[i].lx = lane_step(src[i].lx, src[i].dmag);
         st_in[i].ly = lane_step(src[i].ly, src[i].dmag);
      end

      always_ff @(posedge clock) begin
         if (en) begin
            st_ff[i] <= st_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[QUO_W-2:0], in_valid};
      end
   end

   assign out_valid = v_ff[QUO_W-1];
   assign out_data  = st_ff[QUO_W-1];

endmodule

`default_nettype wire

FILE: hw/rtl/segment_intersection.sv
// -----------------------------------------------------------------------------
// Segment intersection
// Tests two 2D segments given as signed Q15.8 endpoints for intersection and
// returns the crossing point (offset from segment A's start truncated toward
// zero), or hit = 0 with a zero point for parallel, collinear, degenerate or
// missing pairs; touching at an endpoint counts as a hit. One transaction is
// taken per cycle while req_ready is high. Each passes through four front-end
// stages (differences, products, cross terms, hit test), two scaling stages,
// 24 divider stages producing one quotient bit each, and the output register.
// A result the consumer does not take is parked in a one-entry skid register;
// req_ready stays low until it has been taken.
// -----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module segment_intersection (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  segint_pkg::req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output segint_pkg::rsp_type rsp_data
);

   import segint_pkg::*;

   logic      en;
   logic      front_valid, scale_valid, div_valid;
   front_type front_data;
   scale_type scale_data;
   div_type   div_data;

   rsp_type   last_in, last_ff, skid_ff;
   logic      last_v_ff, skid_v_ff;

   logic signed [COORD_W:0] qx_ext, qy_ext, qx_off, qy_off, px_sum, py_sum;

   assign en        = !skid_v_ff;
   assign req_ready = en;

   segint_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .in_data   (req_data),
      .out_valid (front_valid),
      .out_data  (front_data)
   );

   segint_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (front_valid),
      .in_data   (front_data),
      .out_valid (scale_valid),
      .out_data  (scale_data)
   );

   segint_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (scale_valid),
      .in_data   (scale_data),
      .out_valid (div_valid),
      .out_data  (div_data)
   );

   // signed offset onto segment A start
   assign qx_ext = signed'({1'b0, div_data.lx.low});
   assign qy_ext = signed'({1'b0, div_data.ly.low});
   assign qx_off = div_data.sneg_x ? -qx_ext : qx_ext;
   assign qy_off = div_data.sneg_y ? -qy_ext : qy_ext;
   assign px_sum = (COORD_W+1)'(div_data.p0x) + qx_off;
   assign py_sum = (COORD_W+1)'(div_data.p0y) + qy_off;

   always_comb begin
      last_in.hit     = div_data.hit;
      last_in.cross_x = div_data.hit ? px_sum[COORD_W-1:0] : '0;
      last_in.cross_y = div_data.hit ? py_sum[COORD_W-1:0] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_v_ff <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         if (en) begin
            last_v_ff <= div_valid;
         end
         if (skid_v_ff) begin
            if (rsp_ready) begin
               skid_v_ff <= 1'b0;
            end
         end else if (last_v_ff && !rsp_ready) begin
            skid_v_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         last_ff <= last_in;
         skid_ff <= last_ff;
      end
   end

   assign rsp_valid = skid_v_ff || last_v_ff;
   assign rsp_data  = skid_v_ff ? skid_ff : last_ff;

   `ASSERT_IMP(a_miss_zero, clock, reset, rsp_valid && !rsp_data.hit, rsp_data.cross_x == '0 && rsp_data.cross_y == '0)
   `ASSERT_NEXT(a_skid_load, clock, reset, !skid_v_ff && last_v_ff && !rsp_ready, skid_v_ff && skid_ff == $past(last_ff))
   `ASSERT_NEXT(a_skid_hold, clock, reset, skid_v_ff && !rsp_ready, skid_v_ff && $stable(skid_ff) && $stable(last_ff))

endmodule

`default_nettype wire
